@@ hdl/mbss_pkg.sv @@
`default_nettype none

package mbss_pkg;

  localparam int unsigned DefaultCells = 16;
  localparam int unsigned MaxPattern   = 16;
  localparam int unsigned PatBytes     = 16;
  localparam int unsigned PatLimit     = (MaxPattern < PatBytes) ? MaxPattern : PatBytes;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned LenW    = 5;
  localparam int unsigned PosW    = 4;
  localparam int unsigned MaskW   = 16;
  localparam int unsigned PatW    = PatBytes * ByteW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  localparam logic [ByteW-1:0] SkipByte = 8'hCC;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE     = 3'd0,
    REG_PAT_LOW  = 3'd1,
    REG_PAT_HIGH = 3'd2,
    REG_MASK     = 3'd3,
    REG_LENGTH   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic             upd;
    logic             flush;
    logic             skip;
    logic [ByteW-1:0] data;
    logic [LenW-1:0]  len;
    logic [MaskW-1:0] mask;
    logic [PatW-1:0]  pattern;
    logic [AddrW-1:0] byte_index;
  } cell_bcast_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] addr;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/masked_byte_signature_scan.sv @@
// Masked byte signature scanner.
// The slave stream carries the image one byte per transaction in tdata, with
// tlast on the final byte. Each image yields exactly one result transaction on
// the master stream: tuser is the found flag, tdata the match address (base plus
// start index of the earliest match), or zero with found clear at the last byte.
// Bytes after a match are swallowed until tlast, which gives no second result.
// A row of CELLS tracking cells follows overlapping candidates; each byte is
// checked by all cells in the cycle it is accepted, and a free-cell grant ripples
// from one cell to the next. A candidate that finds no free cell is dropped.
// Throughput is one byte per cycle while s_axis_tready is high; a result reaches
// the master side in the cycle after its deciding byte if the buffer is empty.
// The result sits in a two-entry buffer, so a stalled receiver holds the input
// off only once two results wait; s_axis_tready is low only in that case.
// Registers are written over the cfg channel (always ready); the user must write
// them only while idle, the block does not enforce it. 0 base, 1 pattern low,
// 2 pattern high, 3 compare mask, 4 length. Reset clears all cells, the byte
// counter, the buffer, and sets mask all ones, length one, others zero.
`default_nettype none

module masked_byte_signature_scan #(
  parameter int unsigned CELLS = mbss_pkg::DefaultCells
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [mbss_pkg::ByteW-1:0]    s_axis_tdata_i,   // data_byte
  input  wire logic                          s_axis_tlast_i,   // last
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [mbss_pkg::AddrW-1:0]         m_axis_tdata_o,   // match_address
  output logic                               m_axis_tuser_o,   // found
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mbss_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mbss_pkg::CfgW-1:0]     cfg_data_i
);

  logic [mbss_pkg::AddrW-1:0]  base_q;
  logic [mbss_pkg::PatW-1:0]   pattern_q;
  logic [mbss_pkg::MaskW-1:0]  mask_q;
  logic [mbss_pkg::LenW-1:0]   len_q;

  logic [mbss_pkg::AddrW-1:0]  byte_index_q, byte_index_d;
  logic                        scan_done_q, scan_done_d;

  logic [mbss_pkg::LenW-1:0]   eff_len;
  logic                        fire;
  logic                        skip;
  logic                        start_match;
  logic                        len_one;
  logic                        cell_hit;
  logic                        hit;
  logic [mbss_pkg::AddrW-1:0]  sel_start;
  logic [mbss_pkg::AddrW-1:0]  best_start;
  logic                        res_push;
  logic                        buf_full;
  mbss_pkg::result_t           res;
  mbss_pkg::result_t           head;
  mbss_pkg::cell_bcast_t       bc;

  logic [CELLS:0]              grant;
  logic [CELLS-1:0]            survive_vec;
  logic [CELLS-1:0]            alloc_vec;
  logic [CELLS-1:0]            done_vec;
  logic [CELLS-1:0]            win_vec;
  logic [mbss_pkg::AddrW-1:0]  start_arr [CELLS];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      pattern_q <= '0;
      mask_q    <= '1;
      len_q     <= mbss_pkg::LenW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mbss_pkg::REG_BASE:     base_q <= cfg_data_i[mbss_pkg::AddrW-1:0];
        mbss_pkg::REG_PAT_LOW:  pattern_q[mbss_pkg::CfgW-1:0] <= cfg_data_i;
        mbss_pkg::REG_PAT_HIGH: pattern_q[mbss_pkg::PatW-1:mbss_pkg::CfgW] <= cfg_data_i;
        mbss_pkg::REG_MASK:     mask_q <= cfg_data_i[mbss_pkg::MaskW-1:0];
        mbss_pkg::REG_LENGTH:   len_q <= cfg_data_i[mbss_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      eff_len = mbss_pkg::LenW'(1);
    end else if (len_q > mbss_pkg::LenW'(mbss_pkg::PatLimit)) begin
      eff_len = mbss_pkg::LenW'(mbss_pkg::PatLimit);
    end else begin
      eff_len = len_q;
    end
  end

  // byte decode and scan control
  assign s_axis_tready_o = !buf_full;
  assign fire        = s_axis_tvalid_i && s_axis_tready_o;
  assign skip        = (s_axis_tdata_i == mbss_pkg::SkipByte);
  assign start_match = (s_axis_tdata_i == pattern_q[mbss_pkg::ByteW-1:0]);
  assign len_one     = (eff_len == mbss_pkg::LenW'(1));
  assign cell_hit    = |done_vec;
  assign hit         = !scan_done_q && (cell_hit || (start_match && len_one));

  always_comb begin
    sel_start = '0;
    for (int i = 0; i < CELLS; i++) begin
      sel_start = sel_start | (win_vec[i] ? start_arr[i] : '0);
    end
    best_start = cell_hit ? sel_start : byte_index_q;
  end

  always_comb begin
    bc.upd        = fire && !scan_done_q && !hit && !s_axis_tlast_i;
    bc.flush      = fire && (s_axis_tlast_i || hit);
    bc.skip       = skip;
    bc.data       = s_axis_tdata_i;
    bc.len        = eff_len;
    bc.mask       = mask_q;
    bc.pattern    = pattern_q;
    bc.byte_index = byte_index_q;
  end

  always_comb begin
    scan_done_d  = scan_done_q;
    byte_index_d = byte_index_q;
    if (fire) begin
      if (s_axis_tlast_i) begin
        scan_done_d  = 1'b0;
        byte_index_d = '0;
      end else if (hit) begin
        scan_done_d  = 1'b1;
      end else if (!scan_done_q) begin
        byte_index_d = byte_index_q + mbss_pkg::AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_done_q  <= 1'b0;
      byte_index_q <= '0;
    end else begin
      scan_done_q  <= scan_done_d;
      byte_index_q <= byte_index_d;
    end
  end

  // tracking cells, free-cell grant enters at cell 0
  assign grant[0] = start_match && !len_one;

  for (genvar g = 0; g < CELLS; g++) begin : g_cell
    mbss_cell #(
      .CELLS (CELLS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .bc_i          (bc),
      .grant_i       (grant[g]),
      .grant_o       (grant[g+1]),
      .survive_vec_i (survive_vec),
      .alloc_vec_i   (alloc_vec),
      .done_vec_i    (done_vec),
      .survive_o     (survive_vec[g]),
      .alloc_o       (alloc_vec[g]),
      .done_o        (done_vec[g]),
      .win_o         (win_vec[g]),
      .start_o       (start_arr[g])
    );
  end

  // result
  assign res_push  = fire && !scan_done_q && (hit || s_axis_tlast_i);
  assign res.found = hit;
  assign res.addr  = hit ? (base_q + best_start) : '0;

  mbss_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .full_o      (buf_full),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (head)
  );

  assign m_axis_tdata_o = head.addr;
  assign m_axis_tuser_o = head.found;

endmodule

`default_nettype wire

@@ hdl/mbss_cell.sv @@
`default_nettype none

module mbss_cell #(
  parameter int unsigned CELLS = mbss_pkg::DefaultCells
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire mbss_pkg::cell_bcast_t      bc_i,
  input  wire logic                       grant_i,
  output logic                            grant_o,
  input  wire logic [CELLS-1:0]           survive_vec_i,
  input  wire logic [CELLS-1:0]           alloc_vec_i,
  input  wire logic [CELLS-1:0]           done_vec_i,
  output logic                            survive_o,
  output logic                            alloc_o,
  output logic                            done_o,
  output logic                            win_o,
  output logic [mbss_pkg::AddrW-1:0]      start_o
);

  logic                          active_q, active_d;
  logic [mbss_pkg::AddrW-1:0]    start_q;
  logic [mbss_pkg::PosW-1:0]     pos_q;
  logic [mbss_pkg::PosW-1:0]     pidx_q;
  logic [CELLS-1:0]              older_q;

  logic                          cmp_en;
  logic [mbss_pkg::ByteW-1:0]    pbyte;
  logic                          mismatch;
  logic                          step;
  logic [mbss_pkg::LenW-1:0]     pos_inc;
  logic                          reach;

  always_comb begin
    cmp_en   = ({1'b0, pos_q} < bc_i.len) && bc_i.mask[pos_q];
    pbyte    = bc_i.pattern[{pidx_q, 3'b000} +: mbss_pkg::ByteW];
    mismatch = cmp_en && (pbyte != bc_i.data);
    step     = active_q && !bc_i.skip;
    pos_inc  = {1'b0, pos_q} + mbss_pkg::LenW'(1);
    reach    = (pos_inc >= bc_i.len);
  end

  assign done_o    = step && !mismatch && reach;
  assign survive_o = active_q && !(step && (mismatch || reach));
  assign grant_o   = grant_i && survive_o;
  assign alloc_o   = grant_i && !survive_o;
  assign win_o     = done_o && !(|(done_vec_i & older_q));
  assign start_o   = start_q;

  always_comb begin
    active_d = active_q;
    if (bc_i.flush) begin
      active_d = 1'b0;
    end else if (bc_i.upd) begin
      active_d = survive_o || alloc_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // candidate payload, meaningful only while active
  always_ff @(posedge clk_i) begin
    if (bc_i.upd && !bc_i.flush) begin
      if (alloc_o) begin
        start_q <= bc_i.byte_index;
        pos_q   <= mbss_pkg::PosW'(1);
        pidx_q  <= mbss_pkg::PosW'(1);
        older_q <= survive_vec_i;
      end else begin
        older_q <= older_q & ~alloc_vec_i;
        if (step && survive_o) begin
          pos_q  <= pos_inc[mbss_pkg::PosW-1:0];
          pidx_q <= pidx_q + mbss_pkg::PosW'(cmp_en);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/mbss_out_buf.sv @@
`default_nettype none

module mbss_out_buf (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire mbss_pkg::result_t    push_data_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output mbss_pkg::result_t         data_o
);

  logic              head_v_q, head_v_d;
  logic              skid_v_q, skid_v_d;
  mbss_pkg::result_t head_q, head_d;
  mbss_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop     = head_v_q && ready_i;
  assign valid_o = head_v_q;
  assign data_o  = head_q;
  assign full_o  = skid_v_q;

  always_comb begin
    head_v_d = pop ? skid_v_q : head_v_q;
    head_d   = pop ? skid_q : head_q;
    skid_v_d = pop ? 1'b0 : skid_v_q;
    skid_d   = skid_q;
    if (push_i) begin
      if (!head_v_d) begin
        head_v_d = 1'b1;
        head_d   = push_data_i;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

@@ dv/tb_masked_byte_signature_scan.sv @@
`default_nettype none

module tb_masked_byte_signature_scan;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cells      = mbss_pkg::DefaultCells;
  localparam int unsigned WatchLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned HoldAfter  = 1200;
  localparam int unsigned MinBytes   = 1650;

  typedef struct packed {
    logic [mbss_pkg::ByteW-1:0] data;
    logic                       last;
  } img_byte_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [mbss_pkg::ByteW-1:0]   s_axis_tdata_i = '0;   // data_byte
  logic                         s_axis_tlast_i = 1'b0; // last
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [mbss_pkg::AddrW-1:0]   m_axis_tdata_o;        // match_address
  logic                         m_axis_tuser_o;        // found
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [mbss_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [mbss_pkg::CfgW-1:0]    cfg_data_i = '0;

  masked_byte_signature_scan #(
    .CELLS(Cells)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // register copies
  logic [mbss_pkg::AddrW-1:0] cfg_base;
  logic [63:0]                cfg_pat_lo;
  logic [63:0]                cfg_pat_hi;
  logic [mbss_pkg::MaskW-1:0] cfg_mask;
  logic [mbss_pkg::LenW-1:0]  cfg_len;

  // candidate tracking copy
  bit               trk_act   [Cells];
  logic [31:0]      trk_start [Cells];
  int unsigned      trk_pos   [Cells];
  int unsigned      trk_pidx  [Cells];
  logic [31:0]      img_idx;
  bit               img_done;

  img_byte_t          image_bytes[$];
  mbss_pkg::result_t  pending_results[$];
  int unsigned        bytes_queued = 0;
  int unsigned        bytes_taken = 0;
  logic               byte_taken = 1'b0;
  int unsigned        errors = 0;

  img_byte_t        drv_item;
  int unsigned      burst_left = 0;
  int unsigned      gap_left = 0;
  int unsigned      rx_cycle = 0;
  int unsigned      rx_mode = 0;
  int unsigned      hold_left = 0;
  bit               long_hold_done = 1'b0;
  int unsigned      idle_cycles = 0;

  function automatic int unsigned sig_len();
    if (cfg_len == 0) return 1;
    if (cfg_len > mbss_pkg::PatLimit) return mbss_pkg::PatLimit;
    return 32'(cfg_len);
  endfunction

  function automatic logic [7:0] sig_byte(input int unsigned k);
    logic [127:0] p;
    p = {cfg_pat_hi, cfg_pat_lo};
    return p[(k % 16) * 8 +: 8];
  endfunction

  function automatic void clear_tracks();
    foreach (trk_act[c]) trk_act[c] = 1'b0;
    img_idx  = '0;
    img_done = 1'b0;
  endfunction

  function automatic int unsigned queued_images();
    int unsigned n;
    n = 0;
    foreach (image_bytes[i]) if (image_bytes[i].last) n++;
    return n;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic lst);
    int unsigned       len, pos, pidx;
    bit                hit;
    logic [31:0]       age, best_age, best_start;
    mbss_pkg::result_t r;
    len = sig_len();
    hit = 1'b0;
    best_age = '0;
    best_start = '0;
    if (img_done) begin
      if (lst) clear_tracks();
      return;
    end
    if (b != mbss_pkg::SkipByte) begin
      for (int c = 0; c < Cells; c++) begin
        if (!trk_act[c]) continue;
        pos  = trk_pos[c];
        pidx = trk_pidx[c];
        if (pos < len && cfg_mask[pos % 16]) begin
          if (sig_byte(pidx) != b) begin
            trk_act[c] = 1'b0;
            continue;
          end
          pidx++;
        end
        pos++;
        if (pos >= len) begin
          age = img_idx - trk_start[c];
          trk_act[c] = 1'b0;
          if (!hit || age > best_age) begin
            hit = 1'b1;
            best_age = age;
            best_start = trk_start[c];
          end
        end else begin
          trk_pos[c]  = pos & 31;
          trk_pidx[c] = pidx & 31;
        end
      end
    end
    if (b == sig_byte(0)) begin
      if (len == 1) begin
        if (!hit) begin
          hit = 1'b1;
          best_start = img_idx;
        end
      end else begin
        for (int c = 0; c < Cells; c++) begin
          if (!trk_act[c]) begin
            trk_act[c]   = 1'b1;
            trk_start[c] = img_idx;
            trk_pos[c]   = 1;
            trk_pidx[c]  = 1;
            break;
          end
        end
      end
    end
    if (hit) begin
      r.found = 1'b1;
      r.addr  = cfg_base + best_start;
      pending_results.push_back(r);
      if (lst) begin
        clear_tracks();
      end else begin
        foreach (trk_act[c]) trk_act[c] = 1'b0;
        img_done = 1'b1;
      end
      return;
    end
    if (lst) begin
      r = '0;
      pending_results.push_back(r);
      clear_tracks();
      return;
    end
    img_idx++;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic lst);
    img_byte_t item;
    item.data = b;
    item.last = lst;
    image_bytes.push_back(item);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0, 5:    return 8'h41;
      1:       return 8'h42;
      2:       return mbss_pkg::SkipByte;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return sig_byte(0);
      1:       return sig_byte($urandom_range(0, 15));
      2:       return mbss_pkg::SkipByte;
      5:       return 8'h41;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pattern_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[i*8 +: 8] = pick_byte();
    return w;
  endfunction

  // well-formed signature with skip bytes, corrupted, truncated or pure noise
  function automatic void queue_image();
    int unsigned len, k, cut, bad, style;
    logic [7:0]  b;
    len   = sig_len();
    style = $urandom_range(0, 9);
    cut   = (style == 8) ? $urandom_range(0, len - 1) : len;
    bad   = (style == 7) ? $urandom_range(0, len - 1) : len;
    repeat ($urandom_range(0, 6)) queue_byte(noise_byte(), 1'b0);
    if (style != 9) begin
      k = 0;
      for (int unsigned p = 0; p < cut; p++) begin
        if (p > 0) begin
          while ($urandom_range(0, 4) == 0) queue_byte(mbss_pkg::SkipByte, 1'b0);
        end
        if (p == 0 || cfg_mask[p % 16]) begin
          b = sig_byte(k);
          k++;
        end else begin
          b = noise_byte();
        end
        if (p == bad) b = b ^ (8'h01 << $urandom_range(0, 7));
        queue_byte(b, 1'b0);
      end
      if (cut == len) repeat ($urandom_range(0, 4)) queue_byte(noise_byte(), 1'b0);
    end
    queue_byte(noise_byte(), 1'b1);
  endfunction

  task automatic write_reg(input mbss_pkg::cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mbss_pkg::REG_BASE:     cfg_base   = val[mbss_pkg::AddrW-1:0];
      mbss_pkg::REG_PAT_LOW:  cfg_pat_lo = val;
      mbss_pkg::REG_PAT_HIGH: cfg_pat_hi = val;
      mbss_pkg::REG_MASK:     cfg_mask   = val[mbss_pkg::MaskW-1:0];
      mbss_pkg::REG_LENGTH:   cfg_len    = val[mbss_pkg::LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic release_cfg();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_setup(input int unsigned ph);
    logic [63:0] bs, lo, hi, mk, ln;
    bs = {$urandom, $urandom};
    lo = pattern_word();
    hi = pattern_word();
    mk = {$urandom, $urandom};
    ln = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       mk[15:0] = 16'hFFFF;
      1:       mk[15:0] = 16'h0000;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: ln[4:0] = 5'($urandom_range(1, 3));
      3, 4, 5: ln[4:0] = 5'($urandom_range(4, 8));
      6:       ln[4:0] = 5'd16;
      7:       ln[4:0] = 5'd0;
      8:       ln[4:0] = 5'($urandom_range(17, 31));
      default: ln[4:0] = 5'($urandom_range(9, 15));
    endcase
    if (ph % 8 == 0) begin
      bs = 64'hFFFF_FFFF;
      lo = '1;
      hi = '1;
      mk[15:0] = 16'hFFFF;
      ln[4:0] = 5'd16;
    end else if (ph % 8 == 1) begin
      bs = '0;
      lo = '0;
      hi = '0;
      mk[15:0] = 16'h0000;
      ln[4:0] = 5'd31;
    end
    write_reg(mbss_pkg::REG_BASE, bs);
    write_reg(mbss_pkg::REG_PAT_LOW, lo);
    write_reg(mbss_pkg::REG_PAT_HIGH, hi);
    write_reg(mbss_pkg::REG_MASK, mk);
    write_reg(mbss_pkg::REG_LENGTH, ln);
    release_cfg();
  endtask

  // byte transaction side: predict on acceptance
  always @(posedge clk_i) begin
    byte_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      scan_byte(s_axis_tdata_i, s_axis_tlast_i);
      bytes_taken <= bytes_taken + 1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || byte_taken)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0 || image_bytes.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid_i <= 1'b0;
      end else begin
        drv_item = image_bytes.pop_front();
        s_axis_tdata_i  <= drv_item.data;
        s_axis_tlast_i  <= drv_item.last;
        s_axis_tvalid_i <= 1'b1;
        burst_left--;
      end
    end
  end

  // receiver stall pattern with an occasional long hold-off
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (!long_hold_done && rx_cycle >= HoldAfter && queued_images() >= 3) begin
        long_hold_done = 1'b1;
        hold_left = HoldCycles;
      end else if ($urandom_range(0, 4999) == 0) begin
        hold_left = HoldCycles;
      end
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= (rx_cycle % 4) != 3;
        2:       m_axis_tready_i <= 1'($urandom);
        default: m_axis_tready_i <= (rx_cycle % 16) < 4;
      endcase
    end
  end

  always @(posedge clk_i) begin
    mbss_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%b addr=%h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.found) begin
          $display("%0t: found mismatch, expected %b, actual %b",
                   $time, want.found, m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o !== want.addr) begin
          $display("%0t: match_address mismatch, expected %h, actual %h",
                   $time, want.addr, m_axis_tdata_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, WatchLimit);
      $display("tb_masked_byte_signature_scan: errors");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    cfg_base   = '0;
    cfg_pat_lo = '0;
    cfg_pat_hi = '0;
    cfg_mask   = 16'hFFFF;
    cfg_len    = 5'd1;
    clear_tracks();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one-byte signature, match on the last byte, then no match
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b1);

    // all cells busy with skip-byte starts, the dropped start would have matched
    wait_idle();
    write_reg(mbss_pkg::REG_BASE, 64'hFFFF_FFFF);
    write_reg(mbss_pkg::REG_PAT_LOW, 64'h0000_0000_0000_10CC);
    write_reg(mbss_pkg::REG_PAT_HIGH, '1);
    write_reg(mbss_pkg::REG_MASK, 64'h0004);
    write_reg(mbss_pkg::REG_LENGTH, 64'd3);
    release_cfg();
    repeat (16) queue_byte(mbss_pkg::SkipByte, 1'b0);
    queue_byte(8'h20, 1'b0);
    queue_byte(mbss_pkg::SkipByte, 1'b0);
    queue_byte(8'h30, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'h55, 1'b1);

    // length cut below an open candidate, then bytes after the match
    wait_idle();
    write_reg(mbss_pkg::REG_BASE, 64'h1000);
    write_reg(mbss_pkg::REG_PAT_LOW, 64'h0000_0000_0000_00AB);
    write_reg(mbss_pkg::REG_PAT_HIGH, '0);
    write_reg(mbss_pkg::REG_MASK, 64'hFFFF);
    write_reg(mbss_pkg::REG_LENGTH, 64'd16);
    release_cfg();
    queue_byte(8'hAB, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(mbss_pkg::REG_LENGTH, 64'd2);
    release_cfg();
    queue_byte(mbss_pkg::SkipByte, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h99, 1'b0);
    queue_byte(8'h5A, 1'b1);

    phase = 0;
    while (bytes_queued < MinBytes) begin
      wait_idle();
      load_setup(phase);
      repeat ($urandom_range(4, 10)) queue_image();
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_masked_byte_signature_scan: clean");
    end else begin
      $display("tb_masked_byte_signature_scan: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
